/* sv/y2b_pkg.sv */
package y2b_pkg;

    localparam int FracBits     = 16;
    localparam int ChanBits     = 8;
    localparam int OffBits      = ChanBits + 1;
    localparam int ProdBits     = 27;
    localparam int AccBits      = ProdBits + 1;

    localparam logic signed [OffBits-1:0]  LumaOffset   = 9'sd16;
    localparam logic signed [OffBits-1:0]  ChromaOffset = 9'sd128;

    localparam logic signed [ProdBits-1:0] KLuma = 27'sd76309;
    localparam logic signed [ProdBits-1:0] KRCr  = 27'sd104597;
    localparam logic signed [ProdBits-1:0] KGCb  = 27'sd25664;
    localparam logic signed [ProdBits-1:0] KGCr  = 27'sd53268;
    localparam logic signed [ProdBits-1:0] KBCb  = 27'sd132201;

    localparam logic [ChanBits-1:0] ChanMax = 8'd255;
    localparam logic [ChanBits-1:0] ChanMin = 8'd0;

    typedef struct packed {
        logic [ChanBits-1:0] luma_first;
        logic [ChanBits-1:0] chroma_blue;
        logic [ChanBits-1:0] luma_second;
        logic [ChanBits-1:0] chroma_red;
    } macropixel_t;

    typedef struct packed {
        logic [ChanBits-1:0] blue_first;
        logic [ChanBits-1:0] green_first;
        logic [ChanBits-1:0] red_first;
        logic [ChanBits-1:0] blue_second;
        logic [ChanBits-1:0] green_second;
        logic [ChanBits-1:0] red_second;
    } pixel_pair_t;

    typedef struct packed {
        logic signed [ProdBits-1:0] b_cb;
        logic signed [ProdBits-1:0] g_cb;
        logic signed [ProdBits-1:0] g_cr;
        logic signed [ProdBits-1:0] r_cr;
    } chroma_prod_t;

    typedef struct packed {
        logic [ChanBits-1:0] blue;
        logic [ChanBits-1:0] green;
        logic [ChanBits-1:0] red;
    } bgr_t;

endpackage

/* sv/y2b_product.sv */
module y2b_product (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   valid,
    input  y2b_pkg::macropixel_t                   macropixel,
    output logic                                   prod_valid,
    output logic signed [y2b_pkg::ProdBits-1:0]    luma_first,
    output logic signed [y2b_pkg::ProdBits-1:0]    luma_second,
    output y2b_pkg::chroma_prod_t                  chroma
);

    logic                                   off_valid_reg;
    logic signed [y2b_pkg::OffBits-1:0]     y0_off_reg;
    logic signed [y2b_pkg::OffBits-1:0]     y1_off_reg;
    logic signed [y2b_pkg::OffBits-1:0]     u_off_reg;
    logic signed [y2b_pkg::OffBits-1:0]     v_off_reg;
    logic signed [y2b_pkg::OffBits-1:0]     y0_off_next;
    logic signed [y2b_pkg::OffBits-1:0]     y1_off_next;
    logic signed [y2b_pkg::OffBits-1:0]     u_off_next;
    logic signed [y2b_pkg::OffBits-1:0]     v_off_next;

    logic                                   prod_valid_reg;
    logic signed [y2b_pkg::ProdBits-1:0]    yl0_reg;
    logic signed [y2b_pkg::ProdBits-1:0]    yl1_reg;
    y2b_pkg::chroma_prod_t                  chroma_reg;
    logic signed [y2b_pkg::ProdBits-1:0]    yl0_next;
    logic signed [y2b_pkg::ProdBits-1:0]    yl1_next;
    y2b_pkg::chroma_prod_t                  chroma_next;

    always_comb
    begin
        y0_off_next = $signed({1'b0, macropixel.luma_first})  - y2b_pkg::LumaOffset;
        y1_off_next = $signed({1'b0, macropixel.luma_second}) - y2b_pkg::LumaOffset;
        u_off_next  = $signed({1'b0, macropixel.chroma_blue}) - y2b_pkg::ChromaOffset;
        v_off_next  = $signed({1'b0, macropixel.chroma_red})  - y2b_pkg::ChromaOffset;
    end

    always_comb
    begin
        yl0_next         = y2b_pkg::ProdBits'(y0_off_reg) * y2b_pkg::KLuma;
        yl1_next         = y2b_pkg::ProdBits'(y1_off_reg) * y2b_pkg::KLuma;
        chroma_next.b_cb = y2b_pkg::ProdBits'(u_off_reg) * y2b_pkg::KBCb;
        chroma_next.g_cb = y2b_pkg::ProdBits'(u_off_reg) * y2b_pkg::KGCb;
        chroma_next.g_cr = y2b_pkg::ProdBits'(v_off_reg) * y2b_pkg::KGCr;
        chroma_next.r_cr = y2b_pkg::ProdBits'(v_off_reg) * y2b_pkg::KRCr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            off_valid_reg  <= valid;
            prod_valid_reg <= off_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        y0_off_reg <= y0_off_next;
        y1_off_reg <= y1_off_next;
        u_off_reg  <= u_off_next;
        v_off_reg  <= v_off_next;
        yl0_reg    <= yl0_next;
        yl1_reg    <= yl1_next;
        chroma_reg <= chroma_next;
    end

    assign prod_valid  = prod_valid_reg;
    assign luma_first  = yl0_reg;
    assign luma_second = yl1_reg;
    assign chroma      = chroma_reg;

endmodule

/* sv/y2b_channel.sv */
module y2b_channel (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   prod_valid,
    input  logic signed [y2b_pkg::ProdBits-1:0]    luma,
    input  y2b_pkg::chroma_prod_t                  chroma,
    output logic                                   pixel_valid,
    output y2b_pkg::bgr_t                          pixel
);

    logic                                   sum_valid_reg;
    logic signed [y2b_pkg::AccBits-1:0]     b_sum_reg;
    logic signed [y2b_pkg::AccBits-1:0]     g_sum_reg;
    logic signed [y2b_pkg::AccBits-1:0]     r_sum_reg;
    logic signed [y2b_pkg::AccBits-1:0]     b_sum_next;
    logic signed [y2b_pkg::AccBits-1:0]     g_sum_next;
    logic signed [y2b_pkg::AccBits-1:0]     r_sum_next;

    logic                                   pixel_valid_reg;
    y2b_pkg::bgr_t                          pixel_reg;
    y2b_pkg::bgr_t                          pixel_next;

    function automatic logic [y2b_pkg::ChanBits-1:0] clamp_chan(
        input logic signed [y2b_pkg::AccBits-1:0] acc
    );
        logic [y2b_pkg::ChanBits-1:0] res;
        if (acc[y2b_pkg::AccBits-1])
        begin
            res = y2b_pkg::ChanMin;
        end
        else if (|acc[y2b_pkg::AccBits-2:y2b_pkg::FracBits+y2b_pkg::ChanBits])
        begin
            res = y2b_pkg::ChanMax;
        end
        else
        begin
            res = acc[y2b_pkg::FracBits+y2b_pkg::ChanBits-1:y2b_pkg::FracBits];
        end
        return res;
    endfunction

    always_comb
    begin
        b_sum_next = y2b_pkg::AccBits'(luma) + y2b_pkg::AccBits'(chroma.b_cb);
        g_sum_next = y2b_pkg::AccBits'(luma) - y2b_pkg::AccBits'(chroma.g_cb)
                     - y2b_pkg::AccBits'(chroma.g_cr);
        r_sum_next = y2b_pkg::AccBits'(luma) + y2b_pkg::AccBits'(chroma.r_cr);
    end

    always_comb
    begin
        pixel_next.blue  = clamp_chan(b_sum_reg);
        pixel_next.green = clamp_chan(g_sum_reg);
        pixel_next.red   = clamp_chan(r_sum_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg   <= 1'b0;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            sum_valid_reg   <= prod_valid;
            pixel_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_sum_reg <= b_sum_next;
        g_sum_reg <= g_sum_next;
        r_sum_reg <= r_sum_next;
        pixel_reg <= pixel_next;
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel       = pixel_reg;

endmodule

/* sv/yuyv_to_bgr_converter_core.sv */
// Pipeline: an accepted request passes the offset, multiply, sum and clamp
// registers in that order; done is high while the clamped pixels are registered.
// Throughput: one request per cycle; busy never rises, and the receiver
// cannot stall, so nothing holds the pipeline back.
// Reset: rst_n clears the valid bits of every stage; data registers are not reset.
module yuyv_to_bgr_converter_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  y2b_pkg::macropixel_t   macropixel,
    output logic                   done,
    output y2b_pkg::pixel_pair_t   pixels
);

    logic                                   prod_valid;
    logic signed [y2b_pkg::ProdBits-1:0]    yl_first;
    logic signed [y2b_pkg::ProdBits-1:0]    yl_second;
    y2b_pkg::chroma_prod_t                  chroma;
    logic                                   first_valid;
    logic                                   second_valid;
    y2b_pkg::bgr_t                          first_pixel;
    y2b_pkg::bgr_t                          second_pixel;

    assign busy = 1'b0;

    y2b_product u_product (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid       (start & ~busy),
        .macropixel  (macropixel),
        .prod_valid  (prod_valid),
        .luma_first  (yl_first),
        .luma_second (yl_second),
        .chroma      (chroma)
    );

    y2b_channel u_channel_first (
        .clk         (clk),
        .rst_n       (rst_n),
        .prod_valid  (prod_valid),
        .luma        (yl_first),
        .chroma      (chroma),
        .pixel_valid (first_valid),
        .pixel       (first_pixel)
    );

    y2b_channel u_channel_second (
        .clk         (clk),
        .rst_n       (rst_n),
        .prod_valid  (prod_valid),
        .luma        (yl_second),
        .chroma      (chroma),
        .pixel_valid (second_valid),
        .pixel       (second_pixel)
    );

    always_comb
    begin
        pixels.blue_first   = first_pixel.blue;
        pixels.green_first  = first_pixel.green;
        pixels.red_first    = first_pixel.red;
        pixels.blue_second  = second_pixel.blue;
        pixels.green_second = second_pixel.green;
        pixels.red_second   = second_pixel.red;
    end

    assign done = first_valid & second_valid;

endmodule

/* test/tb_yuyv_to_bgr_converter_core.sv */
module tb_yuyv_to_bgr_converter_core;

    localparam int     RandomRequests = 1650;
    localparam int     DrainCycles    = 12;
    localparam longint CycleLimit     = 200000;

    localparam longint LumaBias   = 16;
    localparam longint ChromaBias = 128;
    localparam longint LumaGain   = 76309;
    localparam longint RedCrGain  = 104597;
    localparam longint GreenCbGain = 25664;
    localparam longint GreenCrGain = 53268;
    localparam longint BlueCbGain = 132201;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    y2b_pkg::macropixel_t macropixel = '0;
    logic                 done;
    y2b_pkg::pixel_pair_t pixels;

    y2b_pkg::macropixel_t queued_macropixels[$];
    y2b_pkg::pixel_pair_t predicted_pairs[$];
    int          total_requests = 0;
    int          sent_requests  = 0;
    int          mismatches     = 0;
    longint      cycle_count    = 0;

    yuyv_to_bgr_converter_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .macropixel (macropixel),
        .done       (done),
        .pixels     (pixels)
    );

    function automatic logic [7:0] clamp_channel(longint acc);
        longint whole;
        if (acc < 0)
            return 8'd0;
        whole = acc >>> 16;
        if (whole > 255)
            return 8'd255;
        return whole[7:0];
    endfunction

    function automatic y2b_pkg::bgr_t convert_pixel(logic [7:0] luma, logic [7:0] cb,
                                                    logic [7:0] cr);
        longint        y_term;
        longint        u;
        longint        v;
        y2b_pkg::bgr_t px;
        y_term   = (longint'(luma) - LumaBias) * LumaGain;
        u        = longint'(cb) - ChromaBias;
        v        = longint'(cr) - ChromaBias;
        px.blue  = clamp_channel(y_term + BlueCbGain * u);
        px.green = clamp_channel(y_term - GreenCbGain * u - GreenCrGain * v);
        px.red   = clamp_channel(y_term + RedCrGain * v);
        return px;
    endfunction

    function automatic y2b_pkg::pixel_pair_t convert_macropixel(y2b_pkg::macropixel_t m);
        y2b_pkg::bgr_t        even_px;
        y2b_pkg::bgr_t        odd_px;
        y2b_pkg::pixel_pair_t pair;
        even_px           = convert_pixel(m.luma_first, m.chroma_blue, m.chroma_red);
        odd_px            = convert_pixel(m.luma_second, m.chroma_blue, m.chroma_red);
        pair.blue_first   = even_px.blue;
        pair.green_first  = even_px.green;
        pair.red_first    = even_px.red;
        pair.blue_second  = odd_px.blue;
        pair.green_second = odd_px.green;
        pair.red_second   = odd_px.red;
        return pair;
    endfunction

    task automatic queue_macropixel(logic [7:0] y0, logic [7:0] cb, logic [7:0] y1,
                                    logic [7:0] cr);
        y2b_pkg::macropixel_t m;
        m.luma_first  = y0;
        m.chroma_blue = cb;
        m.luma_second = y1;
        m.chroma_red  = cr;
        queued_macropixels.push_back(m);
    endtask

    task automatic check_channel(string label, logic [7:0] expected, logic [7:0] actual);
        if (expected !== actual)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, expected,
                     actual);
        end
    endtask

    function automatic int sender_idle_percent(int sent);
        case ((sent * 4) / (total_requests > 0 ? total_requests : 1))
            1:       return 71;
            3:       return 11;
            default: return 0;
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("[yuyv_to_bgr_converter_core] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin : drive
        logic                 next_start;
        y2b_pkg::macropixel_t next_px;
        next_start = start;
        next_px    = macropixel;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predicted_pairs.push_back(convert_macropixel(macropixel));
                sent_requests++;
                next_start = 1'b0;
            end
            if (!next_start)
            begin
                if (queued_macropixels.size() > 0 &&
                    $urandom_range(99) >= sender_idle_percent(sent_requests))
                begin
                    next_px    = queued_macropixels.pop_front();
                    next_start = 1'b1;
                end
                else
                begin
                    next_px = y2b_pkg::macropixel_t'($urandom);
                end
            end
        end
        start      <= next_start;
        macropixel <= next_px;
    end

    always @(posedge clk)
    begin : observe
        y2b_pkg::pixel_pair_t expected;
        if (rst_n && done)
        begin
            if (predicted_pairs.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $time, pixels);
            end
            else
            begin
                expected = predicted_pairs.pop_front();
                check_channel("blue_first", expected.blue_first, pixels.blue_first);
                check_channel("green_first", expected.green_first, pixels.green_first);
                check_channel("red_first", expected.red_first, pixels.red_first);
                check_channel("blue_second", expected.blue_second, pixels.blue_second);
                check_channel("green_second", expected.green_second, pixels.green_second);
                check_channel("red_second", expected.red_second, pixels.red_second);
            end
        end
    end

    initial
    begin
        queue_macropixel(8'd0, 8'd0, 8'd0, 8'd0);
        queue_macropixel(8'd255, 8'd255, 8'd255, 8'd255);
        queue_macropixel(8'd16, 8'd128, 8'd16, 8'd128);
        queue_macropixel(8'd235, 8'd128, 8'd235, 8'd128);
        queue_macropixel(8'd15, 8'd128, 8'd236, 8'd128);
        queue_macropixel(8'd0, 8'd255, 8'd255, 8'd0);
        queue_macropixel(8'd255, 8'd0, 8'd0, 8'd255);
        queue_macropixel(8'd128, 8'd0, 8'd128, 8'd0);
        queue_macropixel(8'd128, 8'd255, 8'd128, 8'd255);
        queue_macropixel(8'd128, 8'd0, 8'd128, 8'd255);
        queue_macropixel(8'd128, 8'd255, 8'd128, 8'd0);
        queue_macropixel(8'd126, 8'd128, 8'd127, 8'd128);
        queue_macropixel(8'd16, 8'd16, 8'd235, 8'd240);
        queue_macropixel(8'd235, 8'd240, 8'd16, 8'd16);
        queue_macropixel(8'd81, 8'd90, 8'd81, 8'd240);
        queue_macropixel(8'd145, 8'd54, 8'd145, 8'd34);
        queue_macropixel(8'd41, 8'd240, 8'd41, 8'd110);
        queue_macropixel(8'd170, 8'd166, 8'd170, 8'd16);
        queue_macropixel(8'd20, 8'd130, 8'd250, 8'd126);
        queue_macropixel(8'h55, 8'hAA, 8'h55, 8'hAA);
        queue_macropixel(8'hAA, 8'h55, 8'hAA, 8'h55);
        repeat (RandomRequests)
        begin
            if ($urandom_range(99) < 70)
                queue_macropixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            else
                queue_macropixel(8'($urandom_range(235, 16)), 8'($urandom_range(240, 16)),
                                 8'($urandom_range(235, 16)), 8'($urandom_range(240, 16)));
        end
        total_requests = queued_macropixels.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_requests < total_requests || predicted_pairs.size() > 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (predicted_pairs.size() > 0)
        begin
            mismatches++;
            $display("%0t: %0d results never arrived", $time, predicted_pairs.size());
        end
        if (mismatches == 0)
            $display("[yuyv_to_bgr_converter_core] OK");
        else
            $display("[yuyv_to_bgr_converter_core] ERROR");
        $finish;
    end

endmodule

/* yuyv_to_bgr_converter_core.f */
sv/y2b_pkg.sv
sv/y2b_product.sv
sv/y2b_channel.sv
sv/yuyv_to_bgr_converter_core.sv
test/tb_yuyv_to_bgr_converter_core.sv
